// ===== sv/bitmap_font_glyph_layout_unit_macros.svh =====
// Assertion macros for the checker file of the layout unit.
`ifndef BITMAP_FONT_GLYPH_LAYOUT_UNIT_MACROS_SVH
`define BITMAP_FONT_GLYPH_LAYOUT_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define BFGL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define BFGL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define BFGL_ASSERT_RESET_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfgl_pkg.sv =====
package bfgl_pkg;

    // Table sizes.
    localparam int GLYPH_SLOTS = 256;
    localparam int CODE_SPACE  = 65536;
    localparam int PAGES       = 16;
    localparam int SLOT_BITS   = $clog2(GLYPH_SLOTS);
    localparam int CODE_BITS   = $clog2(CODE_SPACE);

    // Field widths.
    localparam int TEX_W      = 12;
    localparam int MAP_SLOT_W = 8;
    localparam int KIND_W     = 3;
    localparam int MAP_W      = KIND_W + MAP_SLOT_W;
    localparam int RECT_W     = 4 * TEX_W;
    localparam int METRIC_W   = 40;
    localparam int POS_W      = 20;
    localparam int SUM_W      = 20;
    localparam int STEP_W     = 22;
    localparam int ACC_W      = 23;

    // Character codes that the map resets to white space or line breaks.
    localparam int CHAR_TAB    = 9;
    localparam int CHAR_RETURN = 10;
    localparam int CHAR_SPACE  = 32;

    // Queue between the lookup front and the pen back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD_MAP   = 2'd0,
        OP_LOAD_GLYPH = 2'd1,
        OP_START      = 2'd2,
        OP_LAYOUT     = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 3'd0,
        KIND_RETURN = 3'd1,
        KIND_TAB    = 3'd2,
        KIND_SPACE  = 3'd3,
        KIND_GLYPH  = 3'd4
    } kind_t;

    // What the back end does with a word.
    typedef enum logic [2:0] {
        ACT_LOAD,
        ACT_START,
        ACT_RETURN,
        ACT_ADVANCE,
        ACT_GLYPH,
        ACT_SKIP,
        ACT_END
    } act_t;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_SCALE_X     = 3'd2,
        CFG_SCALE_Y     = 3'd3,
        CFG_FONT_WIDTH  = 3'd4,
        CFG_LINE_HEIGHT = 3'd5,
        CFG_PAGE_COUNT  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [11:0]             scale_x;
        logic [11:0]             scale_y;
        logic [9:0]              font_width;
        logic [9:0]              line_height;
        logic [4:0]              page_count;
    } cfg_t;

    // A classified word with its scaled steps, as queued for the back end.
    typedef struct packed {
        act_t                     act;
        logic signed [STEP_W-1:0] step_h;
        logic signed [STEP_W-1:0] off_x;
        logic signed [STEP_W-1:0] step_y;
        logic [TEX_W-1:0]         tex_x;
        logic [TEX_W-1:0]         tex_y;
        logic [TEX_W-1:0]         tex_w;
        logic [TEX_W-1:0]         tex_h;
        logic [3:0]               page;
    } work_t;

    typedef struct packed {
        logic                    emitted;
        logic                    stopped;
        logic signed [POS_W-1:0] screen_x;
        logic signed [POS_W-1:0] screen_y;
        logic [TEX_W-1:0]        tex_x;
        logic [TEX_W-1:0]        tex_y;
        logic [TEX_W-1:0]        tex_w;
        logic [TEX_W-1:0]        tex_h;
        logic [3:0]              page;
        logic [SUM_W-1:0]        total_width;
        logic [SUM_W-1:0]        total_height;
    } result_t;

endpackage

// ===== sv/bfgl_ram.sv =====
module bfgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bfgl_front.sv =====
module bfgl_front import bfgl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [15:0]         s_char_code,
    input  logic [2:0]          s_entry_kind,
    input  logic [7:0]          s_glyph_slot,
    input  logic [11:0]         s_tex_x,
    input  logic [11:0]         s_tex_y,
    input  logic [11:0]         s_tex_width,
    input  logic [11:0]         s_tex_height,
    input  logic signed [11:0]  s_offset_x,
    input  logic signed [11:0]  s_offset_y,
    input  logic [11:0]         s_advance,
    input  logic [3:0]          s_page,
    input  cfg_t                cfg,
    input  logic [QLEVEL_W-1:0] q_level,
    output logic                q_push,
    output work_t               q_item
);

    // Reset contents of one character map entry.
    function automatic logic [MAP_W-1:0] map_reset_entry(input logic [CODE_BITS-1:0] code);
        kind_t k;
        k = KIND_END;
        if (code == CODE_BITS'(CHAR_TAB % CODE_SPACE)) begin
            k = KIND_TAB;
        end else if (code == CODE_BITS'(CHAR_RETURN % CODE_SPACE)) begin
            k = KIND_RETURN;
        end else if (code == CODE_BITS'(CHAR_SPACE % CODE_SPACE)) begin
            k = KIND_SPACE;
        end
        return {k, {MAP_SLOT_W{1'b0}}};
    endfunction

    logic [CODE_BITS:0]         clr_cnt_reg, clr_cnt_next;
    logic                       clearing;
    logic [QLEVEL_W:0]          occupancy;
    logic                       accept;
    op_t                        s_op;
    kind_t                      s_kind;

    logic                       map_we;
    logic [CODE_BITS-1:0]       map_waddr;
    logic [MAP_W-1:0]           map_wdata;
    logic [MAP_W-1:0]           map_rdata;

    logic                       v1_reg, v1_next;
    op_t                        op1_reg;
    logic [SLOT_BITS-1:0]       slot1_reg;
    logic [RECT_W-1:0]          rect1_reg;
    logic [METRIC_W-1:0]        metric1_reg;
    logic                       glyph_we;

    logic                       v2_reg, v2_next;
    op_t                        op2_reg;
    kind_t                      kind2_reg;
    logic [RECT_W-1:0]          rect_rdata;
    logic [METRIC_W-1:0]        metric_rdata;

    logic signed [11:0]         g_ox, g_oy;
    logic [11:0]                g_adv;
    logic [3:0]                 g_page;
    logic                       page_ok;
    logic signed [13:0]         mul_a_op;
    logic signed [12:0]         mul_c_op;
    logic signed [26:0]         prod_a, rnd_a;
    logic [23:0]                prod_b;
    logic [26:0]                rnd_b;
    logic signed [25:0]         prod_c, rnd_c;
    logic signed [STEP_W-1:0]   step_a, step_b, step_c;
    act_t                       act;

    // Map clearing sweep after reset; the top bit marks it finished.
    assign clearing = ~clr_cnt_reg[CODE_BITS];
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    // Take a word only if the queue has room for it and every word ahead.
    assign occupancy = {1'b0, q_level} + (QLEVEL_W + 1)'(v1_reg) + (QLEVEL_W + 1)'(v2_reg);
    assign s_ready   = ~clearing && (occupancy < (QLEVEL_W + 1)'(QUEUE_DEPTH));
    assign accept    = s_valid & s_ready;
    assign s_op      = op_t'(s_operation);
    assign s_kind    = (s_entry_kind inside {[KIND_END:KIND_GLYPH]}) ?
                       kind_t'(s_entry_kind) : KIND_END;

    // Character map write: the clearing sweep, or a map load.
    assign map_we    = clearing | (accept & (s_op == OP_LOAD_MAP));
    assign map_waddr = clearing ? clr_cnt_reg[CODE_BITS-1:0] : s_char_code[CODE_BITS-1:0];
    assign map_wdata = clearing ? map_reset_entry(clr_cnt_reg[CODE_BITS-1:0]) :
                       {s_kind, s_glyph_slot};

    bfgl_ram #(
        .WIDTH (MAP_W),
        .DEPTH (CODE_SPACE)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (s_char_code[CODE_BITS-1:0]),
        .rdata (map_rdata)
    );

    // Stage valid flags and the sweep counter.
    assign v1_next = accept;
    assign v2_next = v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        op1_reg     <= s_op;
        slot1_reg   <= s_glyph_slot[SLOT_BITS-1:0];
        rect1_reg   <= {s_tex_x, s_tex_y, s_tex_width, s_tex_height};
        metric1_reg <= {s_offset_x, s_offset_y, s_advance, s_page};
        op2_reg     <= op1_reg;
        kind2_reg   <= kind_t'(map_rdata[MAP_W-1:MAP_SLOT_W]);
    end

    // Glyph tables: loads write in stage one, lookups read there in word order.
    assign glyph_we = v1_reg && (op1_reg == OP_LOAD_GLYPH);

    bfgl_ram #(
        .WIDTH (RECT_W),
        .DEPTH (GLYPH_SLOTS)
    ) u_rect_ram (
        .aclk  (aclk),
        .we    (glyph_we),
        .waddr (slot1_reg),
        .wdata (rect1_reg),
        .raddr (map_rdata[SLOT_BITS-1:0]),
        .rdata (rect_rdata)
    );

    bfgl_ram #(
        .WIDTH (METRIC_W),
        .DEPTH (GLYPH_SLOTS)
    ) u_metric_ram (
        .aclk  (aclk),
        .we    (glyph_we),
        .waddr (slot1_reg),
        .wdata (metric1_reg),
        .raddr (map_rdata[SLOT_BITS-1:0]),
        .rdata (metric_rdata)
    );

    assign g_ox   = metric_rdata[39:28];
    assign g_oy   = metric_rdata[27:16];
    assign g_adv  = metric_rdata[15:4];
    assign g_page = metric_rdata[3:0];
    assign page_ok = ({1'b0, g_page} < cfg.page_count) && (int'(g_page) < PAGES);

    // Multiplier operands depend on the entry kind.
    always_comb begin
        mul_a_op = '0;
        mul_c_op = {3'b000, cfg.line_height};
        case (kind2_reg)
            KIND_TAB: begin
                mul_a_op = {2'b00, cfg.font_width, 2'b00};
            end
            KIND_SPACE: begin
                mul_a_op = {4'b0000, cfg.font_width};
            end
            KIND_GLYPH: begin
                mul_a_op = {{2{g_ox[11]}}, g_ox};
                // A start word always needs the line height step, whatever its code maps to.
                if (op2_reg == OP_LAYOUT) begin
                    mul_c_op = {g_oy[11], g_oy};
                end
            end
            default: begin
            end
        endcase
    end

    // Scale to sixteenths of a pixel, rounding halves upwards.
    assign prod_a = mul_a_op * $signed({1'b0, cfg.scale_x});
    assign prod_b = g_adv * cfg.scale_x;
    assign prod_c = mul_c_op * $signed({1'b0, cfg.scale_y});
    assign rnd_a  = prod_a + 27'sd8;
    assign rnd_b  = {3'b000, prod_b} + 27'd8;
    assign rnd_c  = prod_c + 26'sd8;
    assign step_a = rnd_a[STEP_W+3:4];
    assign step_b = rnd_b[STEP_W+3:4];
    assign step_c = rnd_c[STEP_W+3:4];

    // Classify the word for the back end.
    always_comb begin
        case (op2_reg)
            OP_START: begin
                act = ACT_START;
            end
            OP_LAYOUT: begin
                case (kind2_reg)
                    KIND_RETURN: act = ACT_RETURN;
                    KIND_TAB,
                    KIND_SPACE:  act = ACT_ADVANCE;
                    KIND_GLYPH:  act = page_ok ? ACT_GLYPH : ACT_SKIP;
                    default:     act = ACT_END;
                endcase
            end
            default: begin
                act = ACT_LOAD;
            end
        endcase
    end

    assign q_push        = v2_reg;
    assign q_item.act    = act;
    assign q_item.step_h = (kind2_reg == KIND_GLYPH) ? step_b : step_a;
    assign q_item.off_x  = step_a;
    assign q_item.step_y = step_c;
    assign q_item.tex_x  = rect_rdata[47:36];
    assign q_item.tex_y  = rect_rdata[35:24];
    assign q_item.tex_w  = rect_rdata[23:12];
    assign q_item.tex_h  = rect_rdata[11:0];
    assign q_item.page   = g_page;

endmodule

// ===== sv/bfgl_fifo.sv =====
module bfgl_fifo import bfgl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  work_t               push_item,
    input  logic                pop,
    output work_t               head,
    output logic                not_empty,
    output logic [QLEVEL_W-1:0] level
);

    work_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QLEVEL_W-1:0] level_reg, level_next;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule

// ===== sv/bfgl_back.sv =====
module bfgl_back import bfgl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  work_t   q_item,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res
);

    localparam logic signed [ACC_W-1:0] ACC_POS_MAX = ACC_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_POS_MIN = -(ACC_W'(1 << (POS_W - 1)));
    localparam logic signed [ACC_W-1:0] ACC_SUM_MAX = ACC_W'((1 << SUM_W) - 1);

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        r = v[POS_W-1:0];
        if (v > ACC_POS_MAX) begin
            r = {1'b0, {(POS_W - 1){1'b1}}};
        end else if (v < ACC_POS_MIN) begin
            r = {1'b1, {(POS_W - 1){1'b0}}};
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
        logic [SUM_W-1:0] r;
        r = v[SUM_W-1:0];
        if (v[ACC_W-1]) begin
            r = '0;
        end else if (v > ACC_SUM_MAX) begin
            r = '1;
        end
        return r;
    endfunction

    logic signed [POS_W-1:0]  pen_x_reg, pen_x_next;
    logic signed [POS_W-1:0]  pen_y_reg, pen_y_next;
    logic [SUM_W-1:0]         wsum_reg, wsum_next;
    logic [SUM_W-1:0]         hsum_reg, hsum_next;
    logic                     ended_reg, ended_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  res_reg, res_next;

    logic signed [STEP_W-1:0] step_h, off_x, step_y;
    logic signed [ACC_W-1:0]  acc_pen_x, acc_pen_y, acc_wsum, acc_hsum;
    logic signed [ACC_W-1:0]  acc_scr_x, acc_scr_y, acc_start_h;

    assign step_h = q_item.step_h;
    assign off_x  = q_item.off_x;
    assign step_y = q_item.step_y;

    // Take the next word when the output register is free or being emptied.
    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    // Candidate sums; each word uses at most four of them.
    assign acc_pen_x   = ACC_W'(pen_x_reg) + ACC_W'(step_h);
    assign acc_pen_y   = ACC_W'(pen_y_reg) + ACC_W'(step_y);
    assign acc_wsum    = $signed(ACC_W'(wsum_reg)) + ACC_W'(step_h);
    assign acc_hsum    = $signed(ACC_W'(hsum_reg)) + ACC_W'(step_y);
    assign acc_scr_x   = ACC_W'(pen_x_reg) + ACC_W'(off_x);
    assign acc_scr_y   = ACC_W'(pen_y_reg) + ACC_W'(step_y);
    assign acc_start_h = ACC_W'(step_y);

    // Pen state and result for the word at the queue head.
    always_comb begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        wsum_next  = wsum_reg;
        hsum_next  = hsum_reg;
        ended_next = ended_reg;
        res_next   = '0;
        case (q_item.act)
            ACT_LOAD: begin
            end
            ACT_START: begin
                pen_x_next = cfg.origin_x;
                pen_y_next = cfg.origin_y;
                wsum_next  = '0;
                hsum_next  = sat_sum(acc_start_h);
                ended_next = 1'b0;
            end
            default: begin
                if (ended_reg) begin
                    res_next.stopped = 1'b1;
                end else begin
                    case (q_item.act)
                        ACT_RETURN: begin
                            pen_x_next = cfg.origin_x;
                            pen_y_next = sat_pos(acc_pen_y);
                            hsum_next  = sat_sum(acc_hsum);
                        end
                        ACT_ADVANCE: begin
                            pen_x_next = sat_pos(acc_pen_x);
                            wsum_next  = sat_sum(acc_wsum);
                        end
                        ACT_GLYPH: begin
                            res_next.emitted  = 1'b1;
                            res_next.screen_x = sat_pos(acc_scr_x);
                            res_next.screen_y = sat_pos(acc_scr_y);
                            res_next.tex_x    = q_item.tex_x;
                            res_next.tex_y    = q_item.tex_y;
                            res_next.tex_w    = q_item.tex_w;
                            res_next.tex_h    = q_item.tex_h;
                            res_next.page     = q_item.page;
                            pen_x_next        = sat_pos(acc_pen_x);
                            wsum_next         = sat_sum(acc_wsum);
                        end
                        ACT_SKIP: begin
                        end
                        default: begin
                            ended_next       = 1'b1;
                            res_next.stopped = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        res_next.total_width  = wsum_next;
        res_next.total_height = hsum_next;
    end

    // Output register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            wsum_reg      <= '0;
            hsum_reg      <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                pen_x_reg <= pen_x_next;
                pen_y_reg <= pen_y_next;
                wsum_reg  <= wsum_next;
                hsum_reg  <= hsum_next;
                ended_reg <= ended_next;
            end
        end
    end

    // Result word.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign res     = res_reg;

endmodule

// ===== sv/bitmap_font_glyph_layout_unit.sv =====
// Channel  Dir  Handshake              Word
// s_       in   s_valid / s_ready      operation, character code, map entry, glyph record
// m_       out  m_valid / m_ready      one layout result for every input word
// cfg_     in   cfg_valid / cfg_ready  register index and write data
//
// One word per cycle is sustained while the output is taken; the map is read at the accepting
// edge, then follow the glyph read, the scaling into the queue and the pen update.
// The back-end pen accumulator is the only serial loop; it runs once per cycle a word is popped.
// After reset the character map is rewritten one entry per cycle, all 65536 entries; s_ready
// stays low meanwhile, while configuration writes are taken at once.
// A stalled output holds its word; a four-entry queue lets the front keep going until it
// and the two lookup stages together hold four words.
module bitmap_font_glyph_layout_unit import bfgl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [15:0]        s_char_code,
    input  logic [2:0]         s_entry_kind,
    input  logic [7:0]         s_glyph_slot,
    input  logic [11:0]        s_tex_x,
    input  logic [11:0]        s_tex_y,
    input  logic [11:0]        s_tex_width,
    input  logic [11:0]        s_tex_height,
    input  logic signed [11:0] s_offset_x,
    input  logic signed [11:0] s_offset_y,
    input  logic [11:0]        s_advance,
    input  logic [3:0]         s_page,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_emitted,
    output logic               m_stopped,
    output logic signed [19:0] m_screen_x,
    output logic signed [19:0] m_screen_y,
    output logic [11:0]        m_out_tex_x,
    output logic [11:0]        m_out_tex_y,
    output logic [11:0]        m_out_width,
    output logic [11:0]        m_out_height,
    output logic [3:0]         m_out_page,
    output logic [19:0]        m_total_width,
    output logic [19:0]        m_total_height,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    cfg_t                cfg_reg;
    logic                cfg_write;
    logic                q_push, q_pop, q_not_empty;
    logic [QLEVEL_W-1:0] q_level;
    work_t               q_in, q_head;
    result_t             res;

    // Configuration registers, always ready.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
            cfg_reg.scale_x     <= 12'd256;
            cfg_reg.scale_y     <= 12'd256;
            cfg_reg.font_width  <= '0;
            cfg_reg.line_height <= '0;
            cfg_reg.page_count  <= 5'd1;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_data;
                CFG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_data;
                CFG_SCALE_X:     cfg_reg.scale_x     <= cfg_data[11:0];
                CFG_SCALE_Y:     cfg_reg.scale_y     <= cfg_data[11:0];
                CFG_FONT_WIDTH:  cfg_reg.font_width  <= cfg_data[9:0];
                CFG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data[9:0];
                CFG_PAGE_COUNT:  cfg_reg.page_count  <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Lookup and classification front.
    bfgl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_char_code  (s_char_code),
        .s_entry_kind (s_entry_kind),
        .s_glyph_slot (s_glyph_slot),
        .s_tex_x      (s_tex_x),
        .s_tex_y      (s_tex_y),
        .s_tex_width  (s_tex_width),
        .s_tex_height (s_tex_height),
        .s_offset_x   (s_offset_x),
        .s_offset_y   (s_offset_y),
        .s_advance    (s_advance),
        .s_page       (s_page),
        .cfg          (cfg_reg),
        .q_level      (q_level),
        .q_push       (q_push),
        .q_item       (q_in)
    );

    // Queue between front and back.
    bfgl_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    // Pen accumulator and output register.
    bfgl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res     (res)
    );

    assign m_emitted      = res.emitted;
    assign m_stopped      = res.stopped;
    assign m_screen_x     = res.screen_x;
    assign m_screen_y     = res.screen_y;
    assign m_out_tex_x    = res.tex_x;
    assign m_out_tex_y    = res.tex_y;
    assign m_out_width    = res.tex_w;
    assign m_out_height   = res.tex_h;
    assign m_out_page     = res.page;
    assign m_total_width  = res.total_width;
    assign m_total_height = res.total_height;

endmodule

// ===== sv/bfgl_checker.sv =====
`include "bitmap_font_glyph_layout_unit_macros.svh"

module bfgl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_emitted,
    input logic               m_stopped,
    input logic signed [19:0] m_screen_x,
    input logic signed [19:0] m_screen_y,
    input logic [11:0]        m_out_tex_x,
    input logic [11:0]        m_out_tex_y,
    input logic [11:0]        m_out_width,
    input logic [11:0]        m_out_height,
    input logic [3:0]         m_out_page,
    input logic [19:0]        m_total_width,
    input logic [19:0]        m_total_height
);

    // A result word waiting for the sink stays valid and keeps its flags, screen x and totals.
    `BFGL_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_emitted) && $stable(m_stopped) && $stable(m_screen_x) && $stable(m_total_width) && $stable(m_total_height), "result word changed while stalled")

    // A drawn glyph never also ends the string.
    `BFGL_ASSERT_SAME(a_quad_not_stopped, m_valid && m_emitted, !m_stopped, "glyph word also marked stopped")

    // Without a glyph, the quad fields read as zero.
    `BFGL_ASSERT_SAME(a_empty_quad_zero, m_valid && !m_emitted, m_screen_x == 20'sd0 && m_screen_y == 20'sd0 && m_out_tex_x == 12'd0 && m_out_tex_y == 12'd0 && m_out_width == 12'd0 && m_out_height == 12'd0 && m_out_page == 4'd0, "quad fields set without a glyph")

    // Reset empties the output and holds off input while the map is cleared.
    `BFGL_ASSERT_RESET_NEXT(a_reset_quiet, !aresetn, !s_ready && !m_valid, "unit active straight after reset")

endmodule

bind bitmap_font_glyph_layout_unit bfgl_checker u_checker (.*);
